// File: sv/bb3_pkg.sv
// ----------------------------------------------------------------------------
// Box blur package
// Shared types and constants of the 3x3 edge-aware box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 1'b1;
  localparam logic [9:0] RESET_WIDTH = 10'd512;
  localparam logic [15:0] RESET_HEIGHT = 16'd512;

  localparam int unsigned SumW = 12;
  localparam int unsigned CntW = 4;
  localparam int unsigned NumW = 13;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_t;

  typedef struct packed {
    logic [7:0]  blur_red;
    logic [7:0]  blur_green;
    logic [7:0]  blur_blue;
    logic [15:0] out_row;
    logic [8:0]  out_col;
    logic        frame_done;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_RD,
    ST_ACC,
    ST_DINIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic start_emit;
    logic rd;
    logic acc;
    logic div_init;
    logic div_step;
    logic load_out;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic pend;
    logic k_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/box_blur_3x3_edge_aware_unit.sv
// Each word is accepted and then yields zero, one or two results.
// Each result goes through three window reads of the line stores, one
// divider set-up and eight steps of the shared restoring divider, then output.
// Reset clears the position counters and control and sets the configuration to
// 512 by 512; line stores are not cleared.
// Box blur top level
// Streaming 3x3 edge-aware box blur of RGB pixels with line stores.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_unit #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bb3_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bb3_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bb3_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0] cfg_data_i
);

  bb3_pkg::cmd_t    cmd;
  bb3_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  bb3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bb3_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// Box blur controller
// Sequences acceptance, window reads, accumulation, division and output.
// ----------------------------------------------------------------------------
module bb3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  bb3_pkg::status_t status_i,
  output bb3_pkg::cmd_t    cmd_o
);

  bb3_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bb3_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bb3_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = bb3_pkg::ST_SEL;
        end
      end
      bb3_pkg::ST_SEL: begin
        if (status_i.pend) begin
          cmd_o.start_emit = 1'b1;
          state_d = bb3_pkg::ST_RD;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d = bb3_pkg::ST_ACC;
      end
      bb3_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = status_i.k_last ? bb3_pkg::ST_DINIT : bb3_pkg::ST_RD;
      end
      bb3_pkg::ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = bb3_pkg::ST_DIV;
      end
      bb3_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = bb3_pkg::ST_EMIT;
        end
      end
      bb3_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = bb3_pkg::ST_SEL;
        end
      end
      default: begin
        state_d = bb3_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bb3_dp.sv
// ----------------------------------------------------------------------------
// Box blur datapath
// Line stores, counters, window accumulation, divider and output register.
// ----------------------------------------------------------------------------
module bb3_dp #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bb3_pkg::cmd_t                    cmd_i,
  output bb3_pkg::status_t                 status_o,
  input  bb3_pkg::in_t                     in_data_i,
  input  logic                             cfg_valid_i,
  input  logic [bb3_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bb3_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bb3_pkg::out_t                    out_data_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = (AW + 1 > 10) ? AW + 1 : 10;
  localparam int unsigned XW = AW + 2;

  logic [9:0]  cfg_w_q;
  logic [15:0] cfg_h_q;

  logic [WW-1:0] w_raw, w_eff;
  logic [AW-1:0] wm1;
  logic [15:0]   h_eff;

  logic [15:0]   row_q;
  logic [AW-1:0] col_q, drain_q;
  logic [1:0]    ptr_q;

  logic          is_data_q, is_drain_q, pend0_q, pend1_q;
  logic [AW-1:0] c_q, x_q;
  logic [15:0]   r_q, erow_q;
  logic          done_q, use_above_q, use_below_q;
  logic [1:0]    k_q;
  logic          in_range_q;

  logic [23:0] mem0 [MAX_WIDTH];
  logic [23:0] mem1 [MAX_WIDTH];
  logic [23:0] mem2 [MAX_WIDTH];
  logic [23:0] rd0_q, rd1_q, rd2_q;
  logic [23:0] old_px, pri_px, cur_px;
  logic [1:0]  cur_bank;

  logic [bb3_pkg::SumW-1:0] sum_q [3];
  logic [bb3_pkg::CntW-1:0] cnt_q;
  logic [bb3_pkg::NumW-1:0] rem_q [3];
  logic [7:0]               quo_q [3];
  logic [4:0]               den_q;
  logic [2:0]               div_i_q;

  logic          out_valid_q;
  bb3_pkg::out_t out_q;

  logic          draining, flush, acc_is_data, acc_is_drain;
  logic [AW-1:0] c_data, c_drain, c_acc;
  logic [XW-1:0] xa;
  logic          xa_ok;

  assign w_raw = WW'(cfg_w_q);
  assign w_eff = (w_raw == '0) ? WW'(1) :
                 ((w_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_raw);
  assign wm1   = AW'(w_eff - WW'(1));
  assign h_eff = (cfg_h_q == '0) ? 16'd1 : cfg_h_q;

  assign draining     = row_q >= h_eff;
  assign flush        = in_data_i.mode;
  assign acc_is_data  = !draining && !flush;
  assign acc_is_drain = draining && flush;
  assign c_data       = (col_q < wm1) ? col_q : wm1;
  assign c_drain      = (drain_q < wm1) ? drain_q : wm1;
  assign c_acc        = acc_is_drain ? c_drain : c_data;

  assign cur_bank = (ptr_q == 2'd0) ? 2'd2 : ptr_q - 2'd1;

  assign xa    = XW'(x_q) + XW'(k_q) - XW'(1);
  assign xa_ok = !xa[XW-1] && (xa[AW:0] <= {1'b0, wm1});

  always_comb begin
    unique case (ptr_q)
      2'd1: begin
        old_px = rd1_q; pri_px = rd2_q; cur_px = rd0_q;
      end
      2'd2: begin
        old_px = rd2_q; pri_px = rd0_q; cur_px = rd1_q;
      end
      default: begin
        old_px = rd0_q; pri_px = rd1_q; cur_px = rd2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= bb3_pkg::RESET_WIDTH;
      cfg_h_q <= bb3_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bb3_pkg::CFG_IMAGE_WIDTH:  cfg_w_q <= cfg_data_i[9:0];
        bb3_pkg::CFG_IMAGE_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      drain_q <= '0;
      ptr_q <= '0;
      pend0_q <= 1'b0;
      pend1_q <= 1'b0;
      is_data_q <= 1'b0;
      is_drain_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        is_data_q <= acc_is_data;
        is_drain_q <= acc_is_drain;
        pend0_q <= acc_is_data && (row_q != '0) && (c_acc != '0);
        pend1_q <= (acc_is_data && (row_q != '0) && (c_acc == wm1)) || acc_is_drain;
      end
      if (cmd_i.start_emit) begin
        if (pend0_q) begin
          pend0_q <= 1'b0;
        end else begin
          pend1_q <= 1'b0;
        end
      end
      if (cmd_i.finish) begin
        if (is_data_q) begin
          if (c_q == wm1) begin
            ptr_q <= (ptr_q == 2'd2) ? 2'd0 : ptr_q + 2'd1;
            col_q <= '0;
            drain_q <= '0;
            row_q <= ({1'b0, r_q} + 17'd1 >= {1'b0, h_eff}) ? h_eff : r_q + 16'd1;
          end else begin
            col_q <= c_q + AW'(1);
          end
        end else if (is_drain_q) begin
          if (c_q == wm1) begin
            row_q <= '0;
            col_q <= '0;
            drain_q <= '0;
          end else begin
            drain_q <= c_q + AW'(1);
          end
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && acc_is_data) begin
      unique case (cur_bank)
        2'd0: mem0[c_acc] <= {in_data_i.pixel_red, in_data_i.pixel_green,
                              in_data_i.pixel_blue};
        2'd1: mem1[c_acc] <= {in_data_i.pixel_red, in_data_i.pixel_green,
                              in_data_i.pixel_blue};
        default: mem2[c_acc] <= {in_data_i.pixel_red, in_data_i.pixel_green,
                                 in_data_i.pixel_blue};
      endcase
    end
    if (cmd_i.rd && xa_ok) begin
      rd0_q <= mem0[xa[AW-1:0]];
      rd1_q <= mem1[xa[AW-1:0]];
      rd2_q <= mem2[xa[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      c_q <= c_acc;
      r_q <= row_q;
    end
    if (cmd_i.start_emit) begin
      x_q <= pend0_q ? c_q - AW'(1) : c_q;
      erow_q <= is_drain_q ? h_eff - 16'd1 : r_q - 16'd1;
      done_q <= is_drain_q && (c_q == wm1);
      use_above_q <= is_drain_q ? (h_eff >= 16'd2) : (r_q >= 16'd2);
      use_below_q <= is_data_q;
      k_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
    end
    if (cmd_i.rd) begin
      in_range_q <= xa_ok;
    end
    if (cmd_i.acc) begin
      k_q <= k_q + 2'd1;
      if (in_range_q) begin
        cnt_q <= cnt_q + bb3_pkg::CntW'(1) + bb3_pkg::CntW'(use_above_q)
               + bb3_pkg::CntW'(use_below_q);
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i]
            + bb3_pkg::SumW'(pri_px[8*(2-i) +: 8])
            + (use_above_q ? bb3_pkg::SumW'(old_px[8*(2-i) +: 8]) : '0)
            + (use_below_q ? bb3_pkg::SumW'(cur_px[8*(2-i) +: 8]) : '0);
        end
      end
    end
    if (cmd_i.div_init) begin
      den_q <= {cnt_q, 1'b0};
      div_i_q <= 3'd7;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= {sum_q[i], 1'b0} + bb3_pkg::NumW'(cnt_q);
        quo_q[i] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      div_i_q <= div_i_q - 3'd1;
      for (int i = 0; i < 3; i++) begin
        if (rem_q[i] >= (bb3_pkg::NumW'(den_q) << div_i_q)) begin
          rem_q[i] <= rem_q[i] - (bb3_pkg::NumW'(den_q) << div_i_q);
          quo_q[i][div_i_q] <= 1'b1;
        end
      end
    end
    if (cmd_i.load_out) begin
      out_q.blur_red <= quo_q[0];
      out_q.blur_green <= quo_q[1];
      out_q.blur_blue <= quo_q[2];
      out_q.out_row <= erow_q;
      out_q.out_col <= 9'(x_q);
      out_q.frame_done <= done_q;
    end
  end

  assign status_o.pend     = pend0_q || pend1_q;
  assign status_o.k_last   = k_q == 2'd2;
  assign status_o.div_last = div_i_q == 3'd0;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box blur testbench
// Streams frames of random RGB pixels, flush words and stray words into the
// box blur, predicts every blurred pixel with an own line-store model and
// checks each output word in order, under random idling and a long stall of
// the output side.
// ----------------------------------------------------------------------------
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bb3_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready;
  bb3_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bb3_pkg::CfgIdxW-1:0] cfg_index = bb3_pkg::CFG_IMAGE_WIDTH;
  logic [bb3_pkg::CfgDataW-1:0] cfg_data = '0;

  box_blur_3x3_edge_aware_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Own model of the block.
  logic [23:0] rows_older[512];
  logic [23:0] rows_prior[512];
  logic [23:0] rows_curr[512];
  int unsigned row_at, col_at, drain_at;
  logic [9:0] width_reg = bb3_pkg::RESET_WIDTH;
  logic [15:0] height_reg = bb3_pkg::RESET_HEIGHT;
  bb3_pkg::out_t blur_q[$];

  bit no_idle = 1'b0;
  bit stall_req = 1'b0;
  bit stall_taken = 1'b0;
  int hold_left;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int frames_sent = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > 512) return 512;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic bb3_pkg::out_t blur_at(bit with_above, bit with_below, int unsigned col,
                                            int unsigned w, int unsigned row, bit done);
    int unsigned sr, sg, sb, cnt, x;
    logic [23:0] p;
    bb3_pkg::out_t o;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int k = 0; k < 3; k++) begin
      if ((k == 0 && !with_above) || (k == 2 && !with_below)) continue;
      for (int d = -1; d <= 1; d++) begin
        if (d < 0 && col == 0) continue;
        x = col + d;
        if (x >= w) continue;
        p = (k == 0) ? rows_older[x] : (k == 1) ? rows_prior[x] : rows_curr[x];
        sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
        cnt++;
      end
    end
    o.blur_red = 8'((2 * sr + cnt) / (2 * cnt));
    o.blur_green = 8'((2 * sg + cnt) / (2 * cnt));
    o.blur_blue = 8'((2 * sb + cnt) / (2 * cnt));
    o.out_row = 16'(row);
    o.out_col = 9'(col);
    o.frame_done = done;
    return o;
  endfunction

  task automatic predict_blur(bb3_pkg::in_t x);
    int unsigned w, h, c, r;
    w = eff_w();
    h = eff_h();
    if (row_at >= h) begin
      if (!x.mode) return;
      c = (drain_at < w - 1) ? drain_at : w - 1;
      blur_q.push_back(blur_at(h >= 2, 1'b0, c, w, h - 1, c == w - 1));
      if (c == w - 1) begin
        row_at = 0; col_at = 0; drain_at = 0;
      end else begin
        drain_at = c + 1;
      end
      return;
    end
    if (x.mode) return;
    c = (col_at < w - 1) ? col_at : w - 1;
    r = row_at;
    rows_curr[c] = {x.pixel_red, x.pixel_green, x.pixel_blue};
    if (r >= 1) begin
      if (c >= 1) blur_q.push_back(blur_at(r >= 2, 1'b1, c - 1, w, r - 1, 1'b0));
      if (c == w - 1) blur_q.push_back(blur_at(r >= 2, 1'b1, c, w, r - 1, 1'b0));
    end
    if (c == w - 1) begin
      rows_older = rows_prior;
      rows_prior = rows_curr;
      col_at = 0;
      drain_at = 0;
      row_at = (r + 1 >= h) ? h : r + 1;
    end else begin
      col_at = c + 1;
    end
  endtask

  // Output side: random ready, with one long hold-off on request.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= 20000) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (blur_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word %p.", out_data);
        end else begin
          bb3_pkg::out_t e;
          e = blur_q.pop_front();
          if (out_data.blur_red !== e.blur_red || out_data.blur_green !== e.blur_green ||
              out_data.blur_blue !== e.blur_blue || out_data.out_row !== e.out_row ||
              out_data.out_col !== e.out_col || out_data.frame_done !== e.frame_done) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p.", e, out_data);
          end
        end
      end
    end
  end

  task automatic send_word(bb3_pkg::in_t x);
    if (!no_idle && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 38);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    predict_blur(x);
  endtask

  task automatic write_reg(logic [bb3_pkg::CfgIdxW-1:0] idx,
                           logic [bb3_pkg::CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == bb3_pkg::CFG_IMAGE_WIDTH) width_reg = val[9:0];
    else height_reg = val;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (blur_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_size(logic [bb3_pkg::CfgDataW-1:0] w, logic [bb3_pkg::CfgDataW-1:0] h);
    wait_drained();
    write_reg(bb3_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  function automatic bb3_pkg::in_t rand_word(bit flush);
    bb3_pkg::in_t x;
    x.mode = flush;
    case ($urandom_range(9))
      0: {x.pixel_red, x.pixel_green, x.pixel_blue} = '1;
      1: {x.pixel_red, x.pixel_green, x.pixel_blue} = '0;
      default: {x.pixel_red, x.pixel_green, x.pixel_blue} = 24'($urandom);
    endcase
    return x;
  endfunction

  task automatic run_frame(int noise_pct);
    int unsigned n;
    n = eff_w() * eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < noise_pct) send_word(rand_word(1'b1));
      send_word(rand_word(1'b0));
    end
    for (int unsigned i = 0; i < eff_w(); i++) begin
      if ($urandom_range(99) < noise_pct) send_word(rand_word(1'b0));
      send_word(rand_word(1'b1));
    end
    frames_sent++;
  endtask

  task automatic test_directed();
    set_size(16'd1, 16'd1);
    send_word('{mode: 1'b0, pixel_red: 8'hff, pixel_green: 8'h00, pixel_blue: 8'hff});
    send_word('{mode: 1'b1, pixel_red: 8'h00, pixel_green: 8'hff, pixel_blue: 8'h00});
    set_size(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) begin
      send_word('{mode: 1'b0, pixel_red: (i % 2) ? 8'hff : 8'h00,
                  pixel_green: 8'hff, pixel_blue: 8'(i * 31)});
    end
    send_word('{mode: 1'b0, pixel_red: 8'hff, pixel_green: 8'hff, pixel_blue: 8'hff});
    for (int i = 0; i < 3; i++) send_word(rand_word(1'b1));
    set_size(16'd1, 16'd3);
    send_word(rand_word(1'b1));
    run_frame(0);
    set_size(16'd4, 16'd1);
    run_frame(0);
  endtask

  task automatic test_size_limits();
    set_size(16'hffff, 16'd2);
    run_frame(0);
    set_size(16'h0000, 16'hffff);
    write_reg(bb3_pkg::CFG_IMAGE_HEIGHT, 16'd2);
    run_frame(5);
  endtask

  task automatic test_output_stall();
    set_size(16'd16, 16'd4);
    no_idle = 1'b0;
    stall_req = 1'b1;
    run_frame(0);
    stall_req = 1'b0;
  endtask

  task automatic test_random_frames();
    int base;
    base = words_sent;
    while (words_sent - base < 200) begin
      no_idle = ($urandom_range(9) == 0);
      if ($urandom_range(3) == 0) set_size(16'($urandom_range(1, 20)),
                                           16'($urandom_range(1, 5)));
      else set_size(16'($urandom_range(1, 6)), 16'($urandom_range(0, 5)));
      run_frame(6);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_limits();
    test_output_stall();
    test_random_frames();
    wait_drained();
    $display("Sent %0d words in %0d frames and checked %0d blurred pixels.",
             words_sent, frames_sent, results_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0 && blur_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
sv/bb3_pkg.sv
sv/bb3_ctrl.sv
sv/bb3_dp.sv
sv/box_blur_3x3_edge_aware_unit.sv
test/testbench.sv
